/* hw/rtl/vomap_pkg.sv */
// Package for the voxel occupancy map engine.
// Holds the item mode codes, occupancy codes, register indexes, reset values,
// controller states and the command and status structs. No dependencies.
package vomap_pkg;

	localparam int DIM_W = 11;

	localparam logic [2:0] MODE_OCC    = 3'd0;
	localparam logic [2:0] MODE_FREE   = 3'd1;
	localparam logic [2:0] MODE_UNK    = 3'd2;
	localparam logic [2:0] MODE_SET_IN = 3'd3;
	localparam logic [2:0] MODE_CLR_IN = 3'd4;
	localparam logic [2:0] MODE_PROJ   = 3'd5;

	localparam logic [3:0] CODE_UNKNOWN   = 4'd0;
	localparam logic [3:0] CODE_FREE_LOW  = 4'd1;
	localparam logic [3:0] CODE_FREE_WRAP = 4'd9;
	localparam logic [3:0] CODE_FREE      = 4'd10;
	localparam logic [3:0] CODE_OCCUPIED  = 4'd15;

	localparam logic [1:0] CFG_DIM_X = 2'd0;
	localparam logic [1:0] CFG_DIM_Y = 2'd1;
	localparam logic [1:0] CFG_DIM_Z = 2'd2;

	localparam logic [8:0] DIM_X_RST = 9'd256;
	localparam logic [8:0] DIM_Y_RST = 9'd256;
	localparam logic [5:0] DIM_Z_RST = 6'd32;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic ready;
		logic clear;
		logic scan;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_proj;
		logic clr_last;
		logic out_free;
	} sts_t;

endpackage

/* hw/rtl/vomap_if.sv */
// Channel interfaces of the voxel occupancy map engine.
// Input words carry one map operation, output words carry one result.
interface vomap_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [7:0] vox_x;
	logic [7:0] vox_y;
	logic [4:0] vox_z;
	logic [4:0] z_last;

	modport source (output valid, mode, vox_x, vox_y, vox_z, z_last, input ready);
	modport sink (input valid, mode, vox_x, vox_y, vox_z, z_last, output ready);
endinterface

interface vomap_out_if;
	logic       valid;
	logic       ready;
	logic       in_map;
	logic [3:0] cell_code;
	logic [3:0] explore_code;

	modport source (output valid, in_map, cell_code, explore_code, input ready);
	modport sink (input valid, in_map, cell_code, explore_code, output ready);
endinterface

/* hw/rtl/voxel_occupancy_map_engine_top.sv */
// Top level of the voxel occupancy map engine.
// Joins the controller and the datapath. Depends on vomap_pkg, the channel
// interfaces, vomap_ctrl and vomap_dp.
//
// Usage: each word on in_ch applies one operation to the voxel grid and
// gives exactly one result word on out_ch. The map is held in one memory
// with a row per (x, y) column, so each item is a single row read followed
// by at most one row write. A point update reads its row on accept; its write,
// if any, and its result come in the EXEC state. A column projection also passes
// the SCAN state in between, which reduces the scanned column to two flags.
// The next word is accepted the cycle after the result is loaded, while
// that result may still wait on out_ch. If the receiver stalls with a
// result pending, the next item holds its read data until the output
// register frees up. After reset the memory is cleared one row a cycle,
// all MAX_X * MAX_Y rows, with in_ch.ready low; dimension writes on the
// cfg port are taken at any time and the dims reset to 256, 256 and 32.
module voxel_occupancy_map_engine_top import vomap_pkg::*; #(
	parameter int MAX_X = 256,
	parameter int MAX_Y = 256,
	parameter int MAX_Z = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	vomap_in_if.sink     in_ch,
	vomap_out_if.source  out_ch,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [8:0]   cfg_data
);

	cmd_t cmd;
	sts_t sts;

	vomap_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	vomap_dp #(
		.MAX_X (MAX_X),
		.MAX_Y (MAX_Y),
		.MAX_Z (MAX_Z)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

/* hw/rtl/vomap_ctrl.sv */
// Controller of the voxel occupancy map engine.
// Sequences the clearing pass, item accept, column scan and commit.
// Depends on vomap_pkg.
module vomap_ctrl import vomap_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (sts.in_valid) begin
					state_nxt = sts.in_proj ? ST_SCAN : ST_EXEC;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

endmodule

/* hw/rtl/vomap_dp.sv */
// Datapath of the voxel occupancy map engine.
// Holds the dimension registers, the column memory, the scan flags and the
// output register. Depends on vomap_pkg and the channel interfaces.
module vomap_dp import vomap_pkg::*; #(
	parameter int MAX_X = 256,
	parameter int MAX_Y = 256,
	parameter int MAX_Z = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	vomap_in_if.sink           in_ch,
	vomap_out_if.source        out_ch,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [8:0]         cfg_data
);

	localparam int ROWS = MAX_X * MAX_Y;
	localparam int AW   = $clog2(ROWS);
	localparam int ZW   = $clog2(MAX_Z);

	// One memory row holds a whole column: occupancy codes, inflation marks
	// and the explore code of that column.
	typedef struct packed {
		logic [3:0]             expl;
		logic [MAX_Z-1:0]       infl;
		logic [MAX_Z-1:0][3:0]  occ;
	} row_t;

	row_t mem [ROWS];
	row_t rd_q;
	row_t row_new;
	row_t wd;

	logic [8:0]      dim_x_q;
	logic [8:0]      dim_y_q;
	logic [5:0]      dim_z_q;
	logic [DIM_W-1:0] eff_x;
	logic [DIM_W-1:0] eff_y;
	logic [DIM_W-1:0] eff_z;

	logic [AW-1:0]   clr_cnt_q;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   addr_q;
	logic [AW-1:0]   wa;
	logic            we;
	logic            accept;
	logic            xy_in;
	logic            z_in;

	logic [2:0]      mode_q;
	logic [4:0]      z_q;
	logic [4:0]      zl_q;
	logic            ok_q;
	logic            zin_q;
	logic [ZW-1:0]   zi;
	logic [3:0]      cur;

	logic [MAX_Z-1:0] known_vec;
	logic [MAX_Z-1:0] infl_vec;
	logic            known_any_q;
	logic            infl_any_q;

	logic            out_valid_q;
	logic            in_map_q;
	logic [3:0]      cell_q;
	logic [3:0]      expl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q <= DIM_X_RST;
			dim_y_q <= DIM_Y_RST;
			dim_z_q <= DIM_Z_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DIM_X: dim_x_q <= cfg_data;
				CFG_DIM_Y: dim_y_q <= cfg_data;
				CFG_DIM_Z: dim_z_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign eff_x = ({2'b00, dim_x_q} > DIM_W'(MAX_X)) ? DIM_W'(MAX_X) : {2'b00, dim_x_q};
	assign eff_y = ({2'b00, dim_y_q} > DIM_W'(MAX_Y)) ? DIM_W'(MAX_Y) : {2'b00, dim_y_q};
	assign eff_z = ({5'b00000, dim_z_q} > DIM_W'(MAX_Z)) ? DIM_W'(MAX_Z)
		: {5'b00000, dim_z_q};

	assign in_ch.ready = cmd.ready;
	assign accept = in_ch.valid && cmd.ready;
	assign xy_in = ({3'b000, in_ch.vox_x} < eff_x) && ({3'b000, in_ch.vox_y} < eff_y);
	assign z_in = {6'b000000, in_ch.vox_z} < eff_z;
	assign rd_addr = AW'({24'd0, in_ch.vox_x} * 32'(MAX_Y) + {24'd0, in_ch.vox_y});

	assign sts.in_valid = in_ch.valid;
	assign sts.in_proj = in_ch.mode == MODE_PROJ;
	assign sts.clr_last = clr_cnt_q == AW'(ROWS - 1);
	assign sts.out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= in_ch.mode;
			z_q <= in_ch.vox_z;
			zl_q <= in_ch.z_last;
			addr_q <= rd_addr;
			zin_q <= z_in;
			ok_q <= (in_ch.mode <= MODE_PROJ) && xy_in && ((in_ch.mode == MODE_PROJ) || z_in);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_comb begin
		for (int k = 0; k < MAX_Z; k++) begin
			known_vec[k] = (9'(k) >= {4'b0000, z_q}) && (9'(k) <= {4'b0000, zl_q})
				&& (DIM_W'(k) < eff_z) && (rd_q.occ[k] != CODE_UNKNOWN);
			infl_vec[k] = (9'(k) >= {4'b0000, z_q}) && (9'(k) <= {4'b0000, zl_q})
				&& (DIM_W'(k) < eff_z) && rd_q.infl[k];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			known_any_q <= |known_vec;
			infl_any_q <= |infl_vec;
		end
	end

	assign zi = ZW'(z_q);
	assign cur = rd_q.occ[zi];

	always_comb begin
		row_new = rd_q;
		unique case (mode_q)
			MODE_OCC:    row_new.occ[zi] = CODE_OCCUPIED;
			MODE_FREE:   row_new.occ[zi] = (cur <= CODE_FREE_LOW) ? CODE_FREE_WRAP : cur - 4'd1;
			MODE_UNK:    row_new.occ[zi] = CODE_UNKNOWN;
			MODE_SET_IN: row_new.infl[zi] = 1'b1;
			MODE_CLR_IN: row_new.infl[zi] = 1'b0;
			MODE_PROJ: begin
				if (infl_any_q) begin
					row_new.expl = CODE_OCCUPIED;
				end else if (known_any_q) begin
					row_new.expl = CODE_FREE;
				end
			end
			default: ;
		endcase
	end

	assign we = cmd.clear || (cmd.commit && ok_q
		&& ((mode_q != MODE_PROJ) || infl_any_q || known_any_q));
	assign wa = cmd.clear ? clr_cnt_q : addr_q;
	assign wd = cmd.clear ? row_t'('0) : row_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			in_map_q <= ok_q;
			cell_q <= (ok_q && zin_q) ? row_new.occ[zi] : CODE_UNKNOWN;
			expl_q <= ok_q ? row_new.expl : CODE_UNKNOWN;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.in_map = in_map_q;
	assign out_ch.cell_code = cell_q;
	assign out_ch.explore_code = expl_q;

endmodule

/* tb/sv/voxel_occupancy_map_engine_top_tb.sv */
// Testbench for the voxel occupancy map engine: directed and random map
// operations, checked word by word against a predictor of the voxel grid.
// Depends on vomap_pkg, the channel interfaces and the engine top level.
module voxel_occupancy_map_engine_top_tb;
	import vomap_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_X = 256;
	localparam int MAX_Y = 256;
	localparam int MAX_Z = 32;

	localparam logic [2:0] MODE_UNDEF_LO = 3'd6;
	localparam logic [2:0] MODE_UNDEF_HI = 3'd7;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] vox_x;
		logic [7:0] vox_y;
		logic [4:0] vox_z;
		logic [4:0] z_last;
	} map_op_t;

	typedef struct packed {
		logic       in_map;
		logic [3:0] cell_code;
		logic [3:0] explore_code;
	} map_result_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;

	vomap_in_if  in_ch();
	vomap_out_if out_ch();

	voxel_occupancy_map_engine_top #(
		.MAX_X(MAX_X),
		.MAX_Y(MAX_Y),
		.MAX_Z(MAX_Z)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [3:0]  occ_codes [int];
	bit          inflate_marks [int];
	logic [3:0]  explore_codes [int];
	int unsigned dim_x_reg = 32'(DIM_X_RST);
	int unsigned dim_y_reg = 32'(DIM_Y_RST);
	int unsigned dim_z_reg = 32'(DIM_Z_RST);

	map_result_t expected_results [$];
	int          mismatch_count = 0;
	int          src_idle_pct = 0;
	int          rcv_idle_pct = 0;
	int          rcv_hold_cycles = 0;
	int unsigned win_x = 0;
	int unsigned win_y = 0;
	int unsigned win_z = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [3:0] occ_code_at(int unsigned addr);
		return occ_codes.exists(addr) ? occ_codes[addr] : CODE_UNKNOWN;
	endfunction

	function automatic bit mark_at(int unsigned addr);
		return inflate_marks.exists(addr) ? inflate_marks[addr] : 1'b0;
	endfunction

	function automatic logic [3:0] explore_code_at(int unsigned col);
		return explore_codes.exists(col) ? explore_codes[col] : CODE_UNKNOWN;
	endfunction

	function automatic map_result_t apply_map_op(map_op_t op);
		map_result_t res;
		int unsigned dx, dy, dz, col, vox, last, k;
		logic [3:0]  code;
		bit          occupied, known;
		dx = (dim_x_reg > MAX_X) ? MAX_X : dim_x_reg;
		dy = (dim_y_reg > MAX_Y) ? MAX_Y : dim_y_reg;
		dz = (dim_z_reg > MAX_Z) ? MAX_Z : dim_z_reg;
		res = '0;
		if (op.mode > MODE_PROJ || op.vox_x >= dx || op.vox_y >= dy ||
		    (op.mode != MODE_PROJ && op.vox_z >= dz))
			return res;
		col = op.vox_x * MAX_Y + op.vox_y;
		vox = col * MAX_Z + op.vox_z;
		occupied = 1'b0;
		known = 1'b0;
		case (op.mode)
		MODE_OCC: occ_codes[vox] = CODE_OCCUPIED;
		MODE_FREE: begin
			code = occ_code_at(vox);
			occ_codes[vox] = (code <= CODE_FREE_LOW) ? CODE_FREE_WRAP : code - 4'd1;
		end
		MODE_UNK: occ_codes[vox] = CODE_UNKNOWN;
		MODE_SET_IN: inflate_marks[vox] = 1'b1;
		MODE_CLR_IN: inflate_marks[vox] = 1'b0;
		default: begin
			if (dz > 0) begin
				last = (op.z_last < dz) ? 32'(op.z_last) : dz - 1;
				for (k = 32'(op.vox_z); k <= last; k++) begin
					if (mark_at(col * MAX_Z + k))
						occupied = 1'b1;
					if (occ_code_at(col * MAX_Z + k) != CODE_UNKNOWN)
						known = 1'b1;
				end
			end
			if (occupied)
				explore_codes[col] = CODE_OCCUPIED;
			else if (known)
				explore_codes[col] = CODE_FREE;
		end
		endcase
		res.in_map = 1'b1;
		res.cell_code = (op.vox_z < dz) ? occ_code_at(vox) : CODE_UNKNOWN;
		res.explore_code = explore_code_at(col);
		return res;
	endfunction

	function automatic map_op_t make_op(logic [2:0] mode, int unsigned x, int unsigned y,
			int unsigned z, int unsigned zl);
		map_op_t op;
		op.mode = mode;
		op.vox_x = 8'(x);
		op.vox_y = 8'(y);
		op.vox_z = 5'(z);
		op.z_last = 5'(zl);
		return op;
	endfunction

	// Most words land in a small window so that updates and scans meet the same voxels.
	function automatic map_op_t rand_op();
		map_op_t op;
		if ($urandom_range(0, 49) == 0)
			op.mode = 3'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI));
		else
			op.mode = 3'($urandom_range(MODE_OCC, MODE_PROJ));
		if ($urandom_range(0, 9) == 0) begin
			op.vox_x = 8'($urandom);
			op.vox_y = 8'($urandom);
			op.vox_z = 5'($urandom);
			op.z_last = 5'($urandom);
		end else begin
			op.vox_x = 8'(win_x + $urandom_range(0, 3));
			op.vox_y = 8'(win_y + $urandom_range(0, 3));
			op.vox_z = 5'(win_z + $urandom_range(0, 7));
			op.z_last = 5'(op.vox_z + $urandom_range(0, 9) - 2);
		end
		return op;
	endfunction

	task automatic send_word(map_op_t op);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= op.mode;
		in_ch.vox_x <= op.vox_x;
		in_ch.vox_y <= op.vox_y;
		in_ch.vox_z <= op.vox_z;
		in_ch.z_last <= op.z_last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		expected_results.push_back(apply_map_op(op));
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_results.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] index, logic [8:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (index)
		CFG_DIM_X: dim_x_reg = 32'(value);
		CFG_DIM_Y: dim_y_reg = 32'(value);
		CFG_DIM_Z: dim_z_reg = 32'(value[5:0]);
		default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_dims(int unsigned dx, int unsigned dy, int unsigned dz);
		write_reg(CFG_DIM_X, 9'(dx));
		write_reg(CFG_DIM_Y, 9'(dy));
		write_reg(CFG_DIM_Z, 9'(dz));
	endtask

	// Free runs give one voxel ten free updates, then a projection of its column.
	task automatic send_random(int n_items);
		int      sent;
		map_op_t op;
		sent = 0;
		while (sent < n_items) begin
			op = rand_op();
			if ($urandom_range(0, 19) == 0) begin
				op.mode = MODE_FREE;
				repeat (10) send_word(op);
				op.mode = MODE_PROJ;
				send_word(op);
				sent += 11;
			end else begin
				send_word(op);
				sent++;
			end
		end
	endtask

	task automatic test_point_updates();
		src_idle_pct = 0;
		rcv_idle_pct = 0;
		send_word(make_op(MODE_OCC, 255, 255, 31, 0));
		send_word(make_op(MODE_FREE, 0, 0, 0, 0));
		send_word(make_op(MODE_FREE, 0, 0, 0, 0));
		send_word(make_op(MODE_FREE, 255, 255, 31, 31));
		send_word(make_op(MODE_UNK, 255, 255, 31, 31));
		send_word(make_op(MODE_SET_IN, 1, 1, 2, 0));
		send_word(make_op(MODE_PROJ, 1, 1, 0, 31));
		send_word(make_op(MODE_CLR_IN, 1, 1, 2, 0));
		send_word(make_op(MODE_OCC, 1, 1, 5, 0));
		send_word(make_op(MODE_PROJ, 1, 1, 0, 31));
		send_word(make_op(MODE_PROJ, 1, 1, 6, 3));
		send_word(make_op(MODE_UNK, 1, 1, 5, 0));
		send_word(make_op(MODE_PROJ, 1, 1, 0, 31));
		send_word(make_op(MODE_UNDEF_LO, 1, 1, 5, 9));
		send_word(make_op(MODE_UNDEF_HI, 255, 255, 31, 31));
		drain();
	endtask

	task automatic test_map_bounds();
		write_dims(3, 2, 4);
		send_word(make_op(MODE_OCC, 3, 0, 0, 0));
		send_word(make_op(MODE_OCC, 2, 1, 3, 0));
		send_word(make_op(MODE_OCC, 0, 2, 0, 0));
		send_word(make_op(MODE_OCC, 0, 0, 4, 0));
		send_word(make_op(MODE_PROJ, 2, 1, 5, 31));
		send_word(make_op(MODE_PROJ, 2, 1, 0, 31));
		drain();
		write_reg(CFG_DIM_X, 9'd0);
		send_word(make_op(MODE_PROJ, 0, 0, 0, 31));
		drain();
		write_dims(511, 511, 9'h1FF);
		send_word(make_op(MODE_OCC, 255, 255, 31, 0));
		send_word(make_op(MODE_PROJ, 255, 255, 0, 31));
		drain();
		write_reg(CFG_DIM_Z, 9'd0);
		send_word(make_op(MODE_PROJ, 255, 255, 0, 31));
		drain();
	endtask

	task automatic test_random_traffic(int src_pct, int rcv_pct, int unsigned dx,
			int unsigned dy, int unsigned dz, int n_items);
		write_dims(dx, dy, dz);
		src_idle_pct = src_pct;
		rcv_idle_pct = rcv_pct;
		win_x = 0;
		win_y = 0;
		win_z = 0;
		send_random(n_items);
		drain();
	endtask

	task automatic test_output_stall();
		write_dims(200, 255, 9'h1D1);
		src_idle_pct = 0;
		rcv_idle_pct = 0;
		win_x = 198;
		win_y = 253;
		win_z = 14;
		send_random(100);
		rcv_hold_cycles = 300;
		send_random(200);
		drain();
	endtask

	initial begin : result_check
		map_result_t want;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result word with no item pending");
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (out_ch.in_map !== want.in_map) begin
						$error("in_map mismatch: expected %0d, got %0d",
							want.in_map, out_ch.in_map);
						mismatch_count++;
					end
					if (out_ch.cell_code !== want.cell_code) begin
						$error("cell_code mismatch: expected %0d, got %0d",
							want.cell_code, out_ch.cell_code);
						mismatch_count++;
					end
					if (out_ch.explore_code !== want.explore_code) begin
						$error("explore_code mismatch: expected %0d, got %0d",
							want.explore_code, out_ch.explore_code);
						mismatch_count++;
					end
				end
			end
			if (rcv_hold_cycles > 0) begin
				rcv_hold_cycles--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_DIM_X;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.mode <= MODE_OCC;
		in_ch.vox_x <= '0;
		in_ch.vox_y <= '0;
		in_ch.vox_z <= '0;
		in_ch.z_last <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_point_updates();
		test_map_bounds();
		test_random_traffic(37, 55, 256, 256, 32, 330);
		test_random_traffic(55, 37, $urandom_range(1, 4), $urandom_range(1, 6),
			$urandom_range(1, 8), 330);
		test_output_stall();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* voxel_occupancy_map_engine_top.f */
hw/rtl/vomap_pkg.sv
hw/rtl/vomap_if.sv
hw/rtl/vomap_ctrl.sv
hw/rtl/vomap_dp.sv
hw/rtl/voxel_occupancy_map_engine_top.sv
tb/sv/voxel_occupancy_map_engine_top_tb.sv
